>>> sv/npe_pkg.sv
// Shared types, constants and saturating Q-format helpers for the Newton
// polynomial extremum block. No dependencies.
`default_nettype none
package npe_pkg;

  localparam int WORD_W = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int COEF_REGS = 5;
  localparam int KFAC_W = 4;
  localparam int IDX_W = 3;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_COEF_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COEF_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COEF_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_COEF_3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_COEF_4 = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOL    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_FD     = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP   = 3'd7;

  localparam word_t RST_COEF_0 = -64'sd25819263327455;
  localparam word_t RST_COEF_1 = 64'sd26565819408184;
  localparam word_t RST_COEF_2 = 64'sd17430249971877;
  localparam word_t RST_COEF_3 = -64'sd24629060462182;
  localparam word_t RST_COEF_4 = 64'sd5497558138880;
  localparam logic [62:0] RST_TOL  = 63'd10995116;
  localparam logic [62:0] RST_STEP = 63'd1099511628;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // evaluation kinds
  localparam logic [1:0] K_POLY = 2'd0;
  localparam logic [1:0] K_D1   = 2'd1;
  localparam logic [1:0] K_D2   = 2'd2;

  // result status
  localparam logic [1:0] ST_CONV  = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;

  // datapath operations
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_LOAD      = 4'd1;
  localparam logic [3:0] OP_EV_SET    = 4'd2;
  localparam logic [3:0] OP_EV_INIT   = 4'd3;
  localparam logic [3:0] OP_MUL       = 4'd4;
  localparam logic [3:0] OP_EV_ADD    = 4'd5;
  localparam logic [3:0] OP_STORE     = 4'd6;
  localparam logic [3:0] OP_DIV       = 4'd7;
  localparam logic [3:0] OP_DIV_STORE = 4'd8;
  localparam logic [3:0] OP_PUBLISH   = 4'd9;

  // evaluation point select
  localparam logic [2:0] EV_X   = 3'd0;
  localparam logic [2:0] EV_XPH = 3'd1;
  localparam logic [2:0] EV_XMH = 3'd2;

  // evaluation store select
  localparam logic [2:0] SD_P0  = 3'd0;
  localparam logic [2:0] SD_FWD = 3'd1;
  localparam logic [2:0] SD_BWD = 3'd2;
  localparam logic [2:0] SD_D1  = 3'd3;
  localparam logic [2:0] SD_D2  = 3'd4;
  localparam logic [2:0] SD_NONE = 3'd5;

  // divide operand select
  localparam logic [2:0] DV_FWD_H = 3'd0;
  localparam logic [2:0] DV_SUM_H = 3'd1;
  localparam logic [2:0] DV_T_H   = 3'd2;
  localparam logic [2:0] DV_D1_D2 = 3'd3;

  // quotient store select
  localparam logic [2:0] DS_D1 = 3'd0;
  localparam logic [2:0] DS_T  = 3'd1;
  localparam logic [2:0] DS_D2 = 3'd2;
  localparam logic [2:0] DS_X  = 3'd3;

  typedef struct packed {
    logic [3:0]       op;
    logic [1:0]       kind;
    logic [IDX_W-1:0] idx;
    logic [2:0]       sel;
  } npe_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic d1_small;
    logic d2_zero;
    logic fd_mode;
  } npe_stat_t;

  function automatic logic [WORD_W-1:0] mag(input word_t v);
    mag = v[WORD_W-1] ? (~v + 64'd1) : v;
  endfunction

  function automatic word_t from_mag(input logic [WORD_W-1:0] m, input logic neg,
                                     input logic ovf);
    if (neg) from_mag = (ovf || m[WORD_W-1]) ? WORD_MIN : word_t'(~m + 64'd1);
    else     from_mag = (ovf || m[WORD_W-1]) ? WORD_MAX : word_t'(m);
  endfunction

  function automatic word_t sadd(input word_t a, input word_t b);
    logic [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) sadd = s[WORD_W] ? WORD_MIN : WORD_MAX;
    else sadd = word_t'(s[WORD_W-1:0]);
  endfunction

  function automatic word_t ssub(input word_t a, input word_t b);
    logic [WORD_W:0] s;
    s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) ssub = s[WORD_W] ? WORD_MIN : WORD_MAX;
    else ssub = word_t'(s[WORD_W-1:0]);
  endfunction

  function automatic word_t smulk(input word_t v, input logic [KFAC_W-1:0] k);
    logic [WORD_W+KFAC_W-1:0] p;
    p = {{KFAC_W{1'b0}}, mag(v)} * {{WORD_W{1'b0}}, k};
    smulk = from_mag(p[WORD_W-1:0], v[WORD_W-1], |p[WORD_W+KFAC_W-1:WORD_W]);
  endfunction

  function automatic logic [KFAC_W-1:0] kfac(input logic [1:0] kind,
                                            input logic [IDX_W-1:0] i);
    logic [2*IDX_W-1:0] pr;
    pr = {{IDX_W{1'b0}}, i} * {{IDX_W{1'b0}}, i - 3'd1};
    unique case (kind)
      K_D1:    kfac = KFAC_W'(i);
      K_D2:    kfac = pr[KFAC_W-1:0];
      default: kfac = 4'd1;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] klo(input logic [1:0] kind);
    unique case (kind)
      K_D1:    klo = 3'd1;
      K_D2:    klo = 3'd2;
      default: klo = 3'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> sv/npe_mul.sv
// Multi-cycle Q-format multiplier: four 32x32 partial products, round, saturate.
// Depends on npe_pkg.
`default_nettype none
module npe_mul #(
  parameter int FRACTION_BITS = 40
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  npe_pkg::word_t     a,
  input  npe_pkg::word_t     b,
  output logic               done,
  output npe_pkg::word_t     result
);
  import npe_pkg::*;

  logic [WORD_W-1:0]   ma, mb;
  logic                neg;
  logic [63:0]         pp;
  logic [127:0]        acc;
  logic [2:0]          step;
  logic                busy;
  logic [31:0]         pa, pb;
  logic [6:0]          sh;
  logic [127:0]        rnd;

  always_comb begin
    unique case (step[1:0])
      2'd0: begin pa = ma[31:0];  pb = mb[31:0];  end
      2'd1: begin pa = ma[31:0];  pb = mb[63:32]; end
      2'd2: begin pa = ma[63:32]; pb = mb[31:0];  end
      default: begin pa = ma[63:32]; pb = mb[63:32]; end
    endcase
    unique case (step)
      3'd1:    sh = 7'd0;
      3'd2:    sh = 7'd32;
      3'd3:    sh = 7'd32;
      default: sh = 7'd64;
    endcase
    rnd = acc + (128'd1 << (FRACTION_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ma   <= mag(a);
        mb   <= mag(b);
        neg  <= a[WORD_W-1] ^ b[WORD_W-1];
        acc  <= '0;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (step < 3'd4) pp <= {32'b0, pa} * {32'b0, pb};
        if (step >= 3'd1 && step <= 3'd4) acc <= acc + ({64'b0, pp} << sh);
        if (step == 3'd5) begin
          result <= from_mag(rnd[FRACTION_BITS +: WORD_W], neg,
                             |rnd[127:FRACTION_BITS+WORD_W]);
          done   <= 1'b1;
          busy   <= 1'b0;
        end
        step <= step + 3'd1;
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/npe_div.sv
// Bit-serial restoring Q-format divider with round to nearest and saturation.
// Depends on npe_pkg.
`default_nettype none
module npe_div #(
  parameter int FRACTION_BITS = 40
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  npe_pkg::word_t     a,
  input  npe_pkg::word_t     b,
  output logic               done,
  output npe_pkg::word_t     result
);
  import npe_pkg::*;

  localparam int STEPS = 2 * WORD_W;
  localparam int CNT_W = $clog2(STEPS);

  logic [STEPS-1:0]  num, quo, qf;
  logic [WORD_W-1:0] den;
  logic [WORD_W:0]   rem, r_sh;
  logic [CNT_W-1:0]  cnt;
  logic              busy, fin, neg, ge, up;

  always_comb begin
    r_sh = {rem[WORD_W-1:0], num[STEPS-1]};
    ge   = r_sh >= {1'b0, den};
    up   = rem[WORD_W-1:0] >= (den - rem[WORD_W-1:0]);
    qf   = quo + {{(STEPS-1){1'b0}}, up};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg <= a[WORD_W-1] ^ b[WORD_W-1];
        num <= {{WORD_W{1'b0}}, mag(a)} << FRACTION_BITS;
        den <= mag(b);
        rem <= '0;
        quo <= '0;
        cnt <= '0;
        if (b == '0) begin
          result <= '0;
          done   <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= ge ? (r_sh - {1'b0, den}) : r_sh;
        quo <= {quo[STEPS-2:0], ge};
        num <= num << 1;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        result <= from_mag(qf[WORD_W-1:0], neg, |qf[STEPS-1:WORD_W]);
        done   <= 1'b1;
        fin    <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/npe_datapath.sv
// Datapath: configuration registers, working registers, Horner step logic,
// shared multiplier and divider. Depends on npe_pkg, npe_mul, npe_div.
`default_nettype none
module npe_datapath #(
  parameter int FRACTION_BITS = 40,
  parameter int COEFF_COUNT = 5
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  npe_pkg::npe_cmd_t                     cmd,
  output npe_pkg::npe_stat_t                    stat,
  input  npe_pkg::word_t                        start_point,
  input  wire logic                             cfg_we,
  input  wire logic [npe_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [npe_pkg::WORD_W-1:0]       cfg_data,
  output npe_pkg::word_t                        result_point,
  output npe_pkg::word_t                        value_at_point
);
  import npe_pkg::*;

  word_t       coef [COEF_REGS];
  logic [62:0] tol, step;
  logic        fd;
  word_t       x, h, ev, acc, p0, fwd, bwd, d1, d2, t;
  word_t       mul_res, div_res, div_a, div_b;
  logic        mul_done, div_done;

  always_comb begin
    unique case (cmd.sel)
      DV_FWD_H: begin div_a = fwd;            div_b = h;  end
      DV_SUM_H: begin div_a = sadd(fwd, bwd); div_b = h;  end
      DV_T_H:   begin div_a = t;              div_b = h;  end
      default:  begin div_a = d1;             div_b = d2; end
    endcase
  end

  npe_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
    .clk(clk), .rst(rst), .start(cmd.op == OP_MUL), .a(acc), .b(ev),
    .done(mul_done), .result(mul_res)
  );

  npe_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk(clk), .rst(rst), .start(cmd.op == OP_DIV), .a(div_a), .b(div_b),
    .done(div_done), .result(div_res)
  );

  assign stat.mul_done = mul_done;
  assign stat.div_done = div_done;
  assign stat.d1_small = mag(d1) <= {1'b0, tol};
  assign stat.d2_zero  = d2 == '0;
  assign stat.fd_mode  = fd;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0] <= RST_COEF_0;
      coef[1] <= RST_COEF_1;
      coef[2] <= RST_COEF_2;
      coef[3] <= RST_COEF_3;
      coef[4] <= RST_COEF_4;
      tol     <= RST_TOL;
      fd      <= 1'b0;
      step    <= RST_STEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COEF_0: coef[0] <= word_t'(cfg_data);
        CFG_COEF_1: coef[1] <= word_t'(cfg_data);
        CFG_COEF_2: coef[2] <= word_t'(cfg_data);
        CFG_COEF_3: coef[3] <= word_t'(cfg_data);
        CFG_COEF_4: coef[4] <= word_t'(cfg_data);
        CFG_TOL:    tol     <= cfg_data[62:0];
        CFG_FD:     fd      <= cfg_data[0];
        default:    step    <= cfg_data[62:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        x <= start_point;
        h <= (step == '0) ? 64'sd1 : word_t'({1'b0, step});
      end
      OP_EV_SET: begin
        unique case (cmd.sel)
          EV_XPH:  ev <= sadd(x, h);
          EV_XMH:  ev <= ssub(x, h);
          default: ev <= x;
        endcase
      end
      OP_EV_INIT: acc <= smulk(coef[COEFF_COUNT-1], kfac(cmd.kind, IDX_W'(COEFF_COUNT-1)));
      OP_EV_ADD:  acc <= sadd(mul_res, smulk(coef[cmd.idx], kfac(cmd.kind, cmd.idx)));
      OP_STORE: begin
        unique case (cmd.sel)
          SD_P0:   p0  <= acc;
          SD_FWD:  fwd <= ssub(acc, p0);
          SD_BWD:  bwd <= ssub(acc, p0);
          SD_D1:   d1  <= acc;
          SD_D2:   d2  <= acc;
          default: ;
        endcase
      end
      OP_DIV_STORE: begin
        unique case (cmd.sel)
          DS_D1:   d1 <= div_res;
          DS_T:    t  <= div_res;
          DS_D2:   d2 <= div_res;
          default: x  <= ssub(x, div_res);
        endcase
      end
      OP_PUBLISH: begin
        result_point   <= x;
        value_at_point <= acc;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> sv/npe_ctrl.sv
// Controller: sequences derivative evaluation, convergence checks, Newton
// updates and result hand-off. Depends on npe_pkg.
`default_nettype none
module npe_ctrl #(
  parameter int MAX_ITERATIONS = 64,
  parameter int COEFF_COUNT = 5
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [6:0]          iterations_used,
  output logic [1:0]          status,
  output npe_pkg::npe_cmd_t   cmd,
  input  npe_pkg::npe_stat_t  stat
);
  import npe_pkg::*;

  localparam int ITW = $clog2(MAX_ITERATIONS + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EV_SET   = 4'd1;
  localparam logic [3:0] S_EV_INIT  = 4'd2;
  localparam logic [3:0] S_EV_MUL   = 4'd3;
  localparam logic [3:0] S_EV_WAIT  = 4'd4;
  localparam logic [3:0] S_EV_ADD   = 4'd5;
  localparam logic [3:0] S_EV_STORE = 4'd6;
  localparam logic [3:0] S_DIV      = 4'd7;
  localparam logic [3:0] S_DIV_WAIT = 4'd8;
  localparam logic [3:0] S_CHECK    = 4'd9;
  localparam logic [3:0] S_D2CHK    = 4'd10;
  localparam logic [3:0] S_FIN      = 4'd11;

  localparam logic [3:0] PH_P0     = 4'd0;
  localparam logic [3:0] PH_FWD    = 4'd1;
  localparam logic [3:0] PH_BWD    = 4'd2;
  localparam logic [3:0] PH_D1     = 4'd3;
  localparam logic [3:0] PH_D2     = 4'd4;
  localparam logic [3:0] PH_VAL    = 4'd5;
  localparam logic [3:0] PH_DIV_D1 = 4'd6;
  localparam logic [3:0] PH_DIV_T  = 4'd7;
  localparam logic [3:0] PH_DIV_D2 = 4'd8;
  localparam logic [3:0] PH_DIV_X  = 4'd9;

  logic [3:0]       state, state_next, phase, phase_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [ITW-1:0]   iters, iters_next;
  logic [1:0]       fin_status, fin_status_next;
  logic [1:0]       kind;
  logic             publish;

  always_comb begin
    unique case (phase)
      PH_D1:   kind = K_D1;
      PH_D2:   kind = K_D2;
      default: kind = K_POLY;
    endcase
  end

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    idx_next        = idx;
    iters_next      = iters;
    fin_status_next = fin_status;
    publish         = 1'b0;
    cmd             = '0;
    cmd.op          = OP_NONE;
    cmd.kind        = kind;
    cmd.idx         = idx;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          iters_next = '0;
          phase_next = stat.fd_mode ? PH_P0 : PH_D1;
          state_next = S_EV_SET;
        end
      end
      S_EV_SET: begin
        cmd.op = OP_EV_SET;
        unique case (phase)
          PH_FWD:  cmd.sel = EV_XPH;
          PH_BWD:  cmd.sel = EV_XMH;
          default: cmd.sel = EV_X;
        endcase
        state_next = S_EV_INIT;
      end
      S_EV_INIT: begin
        cmd.op   = OP_EV_INIT;
        idx_next = IDX_W'(COEFF_COUNT - 2);
        state_next = (IDX_W'(COEFF_COUNT - 2) < klo(kind)) ? S_EV_STORE : S_EV_MUL;
      end
      S_EV_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_EV_WAIT;
      end
      S_EV_WAIT: begin
        if (stat.mul_done) state_next = S_EV_ADD;
      end
      S_EV_ADD: begin
        cmd.op = OP_EV_ADD;
        if (idx == klo(kind)) begin
          state_next = S_EV_STORE;
        end else begin
          idx_next   = idx - 1'b1;
          state_next = S_EV_MUL;
        end
      end
      S_EV_STORE: begin
        cmd.op = OP_STORE;
        unique case (phase)
          PH_P0: begin
            cmd.sel = SD_P0;  phase_next = PH_FWD; state_next = S_EV_SET;
          end
          PH_FWD: begin
            cmd.sel = SD_FWD; phase_next = PH_BWD; state_next = S_EV_SET;
          end
          PH_BWD: begin
            cmd.sel = SD_BWD; phase_next = PH_DIV_D1; state_next = S_DIV;
          end
          PH_D1: begin
            cmd.sel = SD_D1;  state_next = S_CHECK;
          end
          PH_D2: begin
            cmd.sel = SD_D2;  state_next = S_D2CHK;
          end
          default: begin
            cmd.sel = SD_NONE; state_next = S_FIN;
          end
        endcase
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        unique case (phase)
          PH_DIV_D1: cmd.sel = DV_FWD_H;
          PH_DIV_T:  cmd.sel = DV_SUM_H;
          PH_DIV_D2: cmd.sel = DV_T_H;
          default:   cmd.sel = DV_D1_D2;
        endcase
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.op = OP_DIV_STORE;
          unique case (phase)
            PH_DIV_D1: begin
              cmd.sel = DS_D1; state_next = S_CHECK;
            end
            PH_DIV_T: begin
              cmd.sel = DS_T; phase_next = PH_DIV_D2; state_next = S_DIV;
            end
            PH_DIV_D2: begin
              cmd.sel = DS_D2; state_next = S_D2CHK;
            end
            default: begin
              cmd.sel    = DS_X;
              iters_next = iters + 1'b1;
              phase_next = stat.fd_mode ? PH_P0 : PH_D1;
              state_next = S_EV_SET;
            end
          endcase
        end
      end
      S_CHECK: begin
        priority if (stat.d1_small) begin
          fin_status_next = ST_CONV;
          phase_next      = PH_VAL;
          state_next      = S_EV_SET;
        end else if (iters >= ITW'(MAX_ITERATIONS)) begin
          fin_status_next = ST_LIMIT;
          phase_next      = PH_VAL;
          state_next      = S_EV_SET;
        end else begin
          phase_next = stat.fd_mode ? PH_DIV_T : PH_D2;
          state_next = stat.fd_mode ? S_DIV : S_EV_SET;
        end
      end
      S_D2CHK: begin
        if (stat.d2_zero) begin
          fin_status_next = ST_ZERO;
          phase_next      = PH_VAL;
          state_next      = S_EV_SET;
        end else begin
          phase_next = PH_DIV_X;
          state_next = S_DIV;
        end
      end
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          cmd.op     = OP_PUBLISH;
          publish    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_P0;
      idx        <= '0;
      iters      <= '0;
      fin_status <= ST_CONV;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      idx        <= idx_next;
      iters      <= iters_next;
      fin_status <= fin_status_next;
      if (publish) begin
        out_valid       <= 1'b1;
        iterations_used <= 7'(iters);
        status          <= fin_status;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/newton_polynomial_extremum.sv
// Newton stationary-point finder for a polynomial of degree up to four, Q24.40.
// Top level: joins npe_ctrl and npe_datapath. Depends on npe_pkg.
//
// One start point in, one result out. The block works on one item at a time;
// an item takes up to MAX_ITERATIONS Newton updates plus a final evaluation.
// Each Horner step waits on the multi-cycle multiplier, and each quotient runs
// on the shared bit-serial divider: one quotient per update in analytic mode
// and four in finite-difference mode. The output register holds a finished
// result while the next start point is accepted. Configuration is written
// one register per transaction, cfg_ready is always high.
`default_nettype none
module newton_polynomial_extremum #(
  parameter int MAX_ITERATIONS = 64,
  parameter int FRACTION_BITS = 40,
  parameter int COEFF_COUNT = 5
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  npe_pkg::word_t                        start_point,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output npe_pkg::word_t                        result_point,
  output npe_pkg::word_t                        value_at_point,
  output logic [6:0]                            iterations_used,
  output logic [1:0]                            status,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [npe_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [npe_pkg::WORD_W-1:0]       cfg_data
);
  import npe_pkg::*;

  npe_cmd_t  cmd;
  npe_stat_t stat;

  assign cfg_ready = 1'b1;

  npe_ctrl #(
    .MAX_ITERATIONS(MAX_ITERATIONS),
    .COEFF_COUNT(COEFF_COUNT)
  ) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .iterations_used(iterations_used), .status(status),
    .cmd(cmd), .stat(stat)
  );

  npe_datapath #(
    .FRACTION_BITS(FRACTION_BITS),
    .COEFF_COUNT(COEFF_COUNT)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .start_point(start_point),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_point(result_point), .value_at_point(value_at_point)
  );

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_CONV || status == ST_LIMIT || status == ST_ZERO))
    else $error("invalid status code on output");

  a_limit_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_LIMIT) |-> iterations_used == 7'(MAX_ITERATIONS))
    else $error("iteration limit reported with wrong count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted a second item while busy");

endmodule
`default_nettype wire

>>> sim/tb_newton_polynomial_extremum.sv
// Testbench for newton_polynomial_extremum: drives start points, predicts each
// result with a local Newton solver and checks outputs. Depends on npe_pkg.
`default_nettype none
module tb_newton_polynomial_extremum;
  timeunit 1ns;
  timeprecision 1ps;
  import npe_pkg::*;

  typedef struct {
    logic [63:0] pt;
    logic [63:0] val;
    logic [6:0]  iters;
    logic [1:0]  st;
  } solution_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  word_t start_point = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  word_t result_point, value_at_point;
  logic [6:0] iterations_used;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0] cfg_data = '0;

  newton_polynomial_extremum dut (.*);

  always #5 clk = ~clk;

  logic signed [63:0] coef [5];
  logic [62:0] tol_reg, step_reg;
  logic fd_reg;

  word_t pending_points[$];
  solution_t expected_solutions[$];
  int mismatches = 0;
  int in_count = 0;
  int in_seen = 0;
  bit hold_off = 1'b0;
  bit calm = 1'b0;

  function automatic logic [63:0] absval(input logic signed [63:0] v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] sat_mag(input logic [127:0] m, input bit neg);
    if (neg) return (m > 128'h8000000000000000) ? WORD_MIN : -$signed(m[63:0]);
    return (m > 128'h7FFFFFFFFFFFFFFF) ? WORD_MAX : $signed(m[63:0]);
  endfunction

  function automatic logic signed [63:0] qadd(input logic signed [63:0] a, b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh07FFFFFFFFFFFFFFF) return WORD_MAX;
    if (s < -65'sh08000000000000000) return WORD_MIN;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] qsub(input logic signed [63:0] a, b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'sh07FFFFFFFFFFFFFFF) return WORD_MAX;
    if (s < -65'sh08000000000000000) return WORD_MIN;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a, b);
    logic [127:0] p;
    p = {64'd0, absval(a)} * {64'd0, absval(b)};
    p = (p + (128'd1 << 39)) >> 40;
    return sat_mag(p, (a < 0) != (b < 0));
  endfunction

  function automatic logic signed [63:0] qdiv(input logic signed [63:0] a, b);
    logic [127:0] n, d, q, r;
    if (b == 0) return 0;
    n = {64'd0, absval(a)} << 40;
    d = {64'd0, absval(b)};
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;
    return sat_mag(q, (a < 0) != (b < 0));
  endfunction

  function automatic logic signed [63:0] kmul(input logic signed [63:0] v, input int k);
    return sat_mag({64'd0, absval(v)} * k, v < 0);
  endfunction

  function automatic logic signed [63:0] horner(input logic signed [63:0] x, input int order);
    logic signed [63:0] v;
    int k;
    k = (order == 0) ? 1 : (order == 1) ? 4 : 12;
    v = kmul(coef[4], k);
    for (int i = 3; i >= order; i--) begin
      k = (order == 0) ? 1 : (order == 1) ? i : i * (i - 1);
      v = qadd(qmul(v, x), kmul(coef[i], k));
    end
    return v;
  endfunction

  function automatic solution_t solve_extremum(input logic signed [63:0] x0);
    solution_t s;
    logic signed [63:0] x, h, p0, fwd, bwd, d1, d2;
    int n;
    x = x0;
    h = (step_reg == 0) ? 64'sd1 : $signed({1'b0, step_reg});
    n = 0;
    forever begin
      if (fd_reg) begin
        p0 = horner(x, 0);
        fwd = qsub(horner(qadd(x, h), 0), p0);
        bwd = qsub(horner(qsub(x, h), 0), p0);
        d1 = qdiv(fwd, h);
      end else begin
        d1 = horner(x, 1);
      end
      if (absval(d1) <= {1'b0, tol_reg}) begin
        s.st = ST_CONV;
        break;
      end
      if (n >= 64) begin
        s.st = ST_LIMIT;
        break;
      end
      d2 = fd_reg ? qdiv(qdiv(qadd(fwd, bwd), h), h) : horner(x, 2);
      if (d2 == 0) begin
        s.st = ST_ZERO;
        break;
      end
      x = qsub(x, qdiv(d1, d2));
      n++;
    end
    s.pt = x;
    s.val = horner(x, 0);
    s.iters = 7'(n);
    return s;
  endfunction

  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_seen != in_count) begin
        in_seen = in_count;
        if (!hold_off && pending_points.size() > 0
            && (calm || $urandom_range(99) >= 37)) begin
          in_valid <= 1'b1;
          start_point <= pending_points[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !calm && $urandom_range(99) < 37;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      expected_solutions.push_back(solve_extremum(start_point));
      void'(pending_points.pop_front());
      in_count++;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_solutions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: point %h", result_point);
      end else begin
        solution_t e;
        e = expected_solutions.pop_front();
        if (result_point !== e.pt || value_at_point !== e.val
            || iterations_used !== e.iters || status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %0d %0d, got %h %h %0d %0d",
                     e.pt, e.val, e.iters, e.st,
                     result_point, value_at_point, iterations_used, status);
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= CFG_COEF_4) coef[idx] = data;
    else if (idx == CFG_TOL) tol_reg = data[62:0];
    else if (idx == CFG_FD) fd_reg = data[0];
    else step_reg = data[62:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || expected_solutions.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic word_t near_point();
    return word_t'((64'($urandom_range(0, 8)) << 40) - (64'd4 << 40)
                   + (64'($urandom) << 8));
  endfunction

  initial begin
    coef[0] = RST_COEF_0;
    coef[1] = RST_COEF_1;
    coef[2] = RST_COEF_2;
    coef[3] = RST_COEF_3;
    coef[4] = RST_COEF_4;
    tol_reg = RST_TOL;
    step_reg = RST_STEP;
    fd_reg = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    pending_points.push_back(0);
    pending_points.push_back(64'sd1 << 40);
    pending_points.push_back(-(64'sd3 << 40));
    pending_points.push_back(WORD_MAX);
    pending_points.push_back(WORD_MIN);
    pending_points.push_back(-64'sd1);
    drain();

    hold_off = 1'b1;
    write_reg(CFG_FD, 64'd1);
    hold_off = 1'b0;
    pending_points.push_back(64'sd2 << 40);
    pending_points.push_back(-(64'sd1 << 40));
    pending_points.push_back(WORD_MAX);
    drain();

    write_reg(CFG_STEP, 64'd0);
    pending_points.push_back(64'sd1 << 40);
    drain();
    write_reg(CFG_STEP, 64'h7FFFFFFFFFFFFFFF);
    pending_points.push_back(64'sd5 << 40);
    pending_points.push_back(WORD_MIN);
    drain();

    write_reg(CFG_FD, 64'd0);
    write_reg(CFG_COEF_4, 64'd0);
    write_reg(CFG_COEF_3, 64'd0);
    write_reg(CFG_COEF_2, 64'd0);
    pending_points.push_back(64'sd7 << 40);
    drain();
    write_reg(CFG_COEF_0, 64'h7FFFFFFFFFFFFFFF);
    write_reg(CFG_COEF_1, 64'h8000000000000000);
    write_reg(CFG_COEF_2, 64'h7FFFFFFFFFFFFFFF);
    write_reg(CFG_COEF_3, 64'h8000000000000000);
    write_reg(CFG_COEF_4, 64'h7FFFFFFFFFFFFFFF);
    write_reg(CFG_TOL, 64'd0);
    pending_points.push_back(64'sd3 << 40);
    pending_points.push_back(WORD_MIN);
    drain();
    write_reg(CFG_TOL, 64'hFFFFFFFFFFFFFFFF);
    pending_points.push_back(64'sd9 << 40);
    drain();

    for (int phase = 0; phase < 7; phase++) begin
      calm = (phase == 3);
      write_reg(CFG_COEF_0, rand_word() >>> $urandom_range(0, 20));
      write_reg(CFG_COEF_1, $signed(rand_word()) >>> $urandom_range(16, 24));
      write_reg(CFG_COEF_2, $signed(rand_word()) >>> $urandom_range(16, 24));
      write_reg(CFG_COEF_3, $signed(rand_word()) >>> $urandom_range(18, 26));
      write_reg(CFG_COEF_4, (phase == 5) ? 64'd0
                : ($signed(rand_word()) >>> $urandom_range(18, 26)));
      write_reg(CFG_TOL, (phase == 6) ? rand_word() : 64'($urandom_range(0, 1 << 28)));
      write_reg(CFG_FD, phase % 3 == 1 ? rand_word() | 1 : rand_word() & ~64'd1);
      write_reg(CFG_STEP, (phase == 4) ? rand_word() : 64'($urandom_range(1, 1 << 31)));
      for (int i = 0; i < 20; i++)
        pending_points.push_back($urandom_range(99) < 85 ? near_point() : rand_word());
      drain();
    end
    calm = 1'b0;
    if (mismatches == 0 && expected_solutions.size() == 0) begin
      $display("tb_newton_polynomial_extremum passed");
    end else begin
      $display("tb_newton_polynomial_extremum failed");
    end
    $finish;
  end

  initial begin
    #500ms;
    $display("tb_newton_polynomial_extremum failed");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
sv/npe_pkg.sv
sv/npe_mul.sv
sv/npe_div.sv
sv/npe_datapath.sv
sv/npe_ctrl.sv
sv/newton_polynomial_extremum.sv
sim/tb_newton_polynomial_extremum.sv
